// ===== sv/irfb_pkg.sv =====
// ----------------------------------------------------------------------------
// irfb_pkg
// types, frame constants and word encoding shared by the report frame builder
// ----------------------------------------------------------------------------
package irfb_pkg;

	localparam int NUM_WORDS  = 9;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] HDR0      = 8'hA5;
	localparam logic [7:0] HDR1      = 8'h5A;
	localparam logic [7:0] TRAILER   = 8'hAA;
	localparam logic [7:0] RAW_LEN   = 8'd22;
	localparam logic [7:0] ATT_LEN   = 8'd18;
	localparam logic [7:0] RAW_TYPE  = 8'hA2;
	localparam logic [7:0] ATT_TYPE  = 8'hA1;
	localparam logic [7:0] RAW_SEED  = 8'hB8;
	localparam logic [7:0] ATT_SEED  = 8'hB3;

	localparam logic MODE_RAW = 1'b0;
	localparam logic MODE_ATT = 1'b1;

	// byte positions inside a frame
	localparam logic [4:0] POS_HDR0    = 5'd0;
	localparam logic [4:0] POS_HDR1    = 5'd1;
	localparam logic [4:0] POS_LEN     = 5'd2;
	localparam logic [4:0] POS_TYPE    = 5'd3;
	localparam logic [4:0] POS_DATA    = 5'd4;
	localparam logic [4:0] RAW_CSUM    = 5'd22;
	localparam logic [4:0] ATT_CSUM    = 5'd18;
	localparam logic [4:0] RAW_LAST    = 5'd23;
	localparam logic [4:0] ATT_LAST    = 5'd19;

	typedef struct packed {
		logic              mode;
		logic signed [15:0] value_0;
		logic signed [15:0] value_1;
		logic signed [15:0] value_2;
		logic signed [15:0] value_3;
		logic signed [15:0] value_4;
		logic signed [15:0] value_5;
		logic signed [15:0] value_6;
		logic signed [15:0] value_7;
		logic signed [15:0] value_8;
	} req_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frm_t;

	// encoded request as it waits in the queue
	typedef struct packed {
		logic                       mode;
		logic [NUM_WORDS-1:0][15:0] words;
	} enc_t;

	// sign-magnitude word, most negative value clamps to full magnitude
	function automatic logic [15:0] sign_mag(input logic [15:0] v);
		logic [15:0] neg;
		begin
			neg = 16'd0 - v;
			if (!v[15]) begin
				sign_mag = v;
			end else if (v == 16'h8000) begin
				sign_mag = 16'hFFFF;
			end else begin
				sign_mag = {1'b1, neg[14:0]};
			end
		end
	endfunction

endpackage

// ===== sv/irfb_front.sv =====
// ----------------------------------------------------------------------------
// irfb_front
// accepts requests, encodes the data words and pushes them into the queue
// ----------------------------------------------------------------------------
module irfb_front (
	input  irfb_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_ready,
	input  logic           q_full,
	output logic           q_push,
	output irfb_pkg::enc_t q_wdata
);
	import irfb_pkg::*;

	assign req_ready = !q_full;
	assign q_push    = req_valid && !q_full;

	always_comb begin
		q_wdata.mode     = req.mode;
		q_wdata.words[0] = sign_mag(req.value_0);
		q_wdata.words[1] = sign_mag(req.value_1);
		q_wdata.words[2] = sign_mag(req.value_2);
		q_wdata.words[3] = sign_mag(req.value_3);
		q_wdata.words[4] = sign_mag(req.value_4);
		q_wdata.words[5] = sign_mag(req.value_5);
		// attitude frame sends the update rate as raw bits
		q_wdata.words[6] = (req.mode == MODE_ATT) ? req.value_6 : sign_mag(req.value_6);
		q_wdata.words[7] = sign_mag(req.value_7);
		q_wdata.words[8] = sign_mag(req.value_8);
	end

endmodule

// ===== sv/irfb_fifo.sv =====
// ----------------------------------------------------------------------------
// irfb_fifo
// short queue of encoded requests between front and back
// ----------------------------------------------------------------------------
module irfb_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  irfb_pkg::enc_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output irfb_pkg::enc_t rdata
);
	import irfb_pkg::*;

	enc_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	assign full     = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("queue count out of range");

endmodule

// ===== sv/irfb_back.sv =====
// ----------------------------------------------------------------------------
// irfb_back
// frame serializer: one byte per cycle into an output register
// ----------------------------------------------------------------------------
module irfb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_nonempty,
	input  irfb_pkg::enc_t q_rdata,
	output logic           q_pop,
	output irfb_pkg::frm_t frm,
	output logic           frm_valid,
	input  logic           frm_ready
);
	import irfb_pkg::*;

	logic       active_q;
	logic [4:0] idx_q;
	enc_t       cur_q;
	logic [7:0] sum_q;
	frm_t       out_q;
	logic       out_valid_q;

	logic       advance;
	logic       is_last;
	logic       is_data;
	logic [4:0] csum_pos;
	logic [4:0] last_pos;
	logic [4:0] dofs;
	logic [3:0] widx;
	logic [15:0] word;
	logic [7:0] byte_d;

	assign csum_pos = (cur_q.mode == MODE_ATT) ? ATT_CSUM : RAW_CSUM;
	assign last_pos = (cur_q.mode == MODE_ATT) ? ATT_LAST : RAW_LAST;
	assign advance  = active_q && (!out_valid_q || frm_ready);
	assign is_last  = (idx_q == last_pos);
	assign is_data  = (idx_q >= POS_DATA) && (idx_q < csum_pos);
	assign q_pop    = q_nonempty && (!active_q || (advance && is_last));
	assign dofs     = idx_q - POS_DATA;
	assign widx     = dofs[4:1];

	always_comb begin
		case (widx)
			4'd0:    word = cur_q.words[0];
			4'd1:    word = cur_q.words[1];
			4'd2:    word = cur_q.words[2];
			4'd3:    word = cur_q.words[3];
			4'd4:    word = cur_q.words[4];
			4'd5:    word = cur_q.words[5];
			4'd6:    word = cur_q.words[6];
			4'd7:    word = cur_q.words[7];
			4'd8:    word = cur_q.words[8];
			default: word = 16'd0;
		endcase
	end

	always_comb begin
		if (idx_q == POS_HDR0) begin
			byte_d = HDR0;
		end else if (idx_q == POS_HDR1) begin
			byte_d = HDR1;
		end else if (idx_q == POS_LEN) begin
			byte_d = (cur_q.mode == MODE_ATT) ? ATT_LEN : RAW_LEN;
		end else if (idx_q == POS_TYPE) begin
			byte_d = (cur_q.mode == MODE_ATT) ? ATT_TYPE : RAW_TYPE;
		end else if (idx_q == csum_pos) begin
			byte_d = sum_q;
		end else if (is_last) begin
			byte_d = TRAILER;
		end else begin
			// high byte first
			byte_d = dofs[0] ? word[7:0] : word[15:8];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rdata;
			sum_q <= (q_rdata.mode == MODE_ATT) ? ATT_SEED : RAW_SEED;
		end else if (advance && is_data) begin
			sum_q <= sum_q + byte_d;
		end
		if (advance) begin
			out_q.frame_byte <= byte_d;
			out_q.last_byte  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
				if (is_last) begin
					active_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (frm_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign frm       = out_q;
	assign frm_valid = out_valid_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q <= last_pos))
		else $error("byte index past end of frame");
	a_last_is_trailer: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last_byte) |-> (out_q.frame_byte == TRAILER))
		else $error("last flag on a byte other than the trailer");
	a_pop_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && active_q) |-> is_last)
		else $error("new frame loaded before the current one ended");

endmodule

// ===== sv/imu_report_frame_builder.sv =====
// ----------------------------------------------------------------------------
// imu_report_frame_builder
// turns one report request into a framed, checksummed byte stream
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one request: mode plus nine
//   signed 16-bit values. frm channel (frm_valid/frm_ready/frm) gives the
//   frame one byte per result, last_byte set on the closing AA byte.
//   A raw frame is 24 bytes, an attitude frame 20 bytes.
//   Throughput: one byte per cycle while frm_ready is high; frames follow
//   each other with no gap when the next request is already queued.
//   A two-entry queue holds encoded requests, so req_ready stays high while
//   the serializer works on an earlier frame, until the queue is full.
//   When the receiver stalls, the output register holds its byte and the
//   serializer waits; the queue then fills and req_ready drops.
//   Reset clears the queue and the serializer; no frame is in flight after.
// ----------------------------------------------------------------------------
module imu_report_frame_builder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  irfb_pkg::req_t req,
	output logic           frm_valid,
	input  logic           frm_ready,
	output irfb_pkg::frm_t frm
);
	import irfb_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_nonempty;
	enc_t q_wdata;
	enc_t q_rdata;

	irfb_front u_front (
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	irfb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_rdata)
	);

	irfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.frm        (frm),
		.frm_valid  (frm_valid),
		.frm_ready  (frm_ready)
	);

endmodule
